// ----- sv/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/htwd_pkg.sv -----
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package htwd_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX    = 2'd1;

  // Input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // One tree node as held in the node table
  typedef struct packed {
    logic              leaf;
    logic signed [9:0] left;
    logic signed [9:0] right;
    logic [7:0]        symbol;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Node seen when the root lies outside the table: inner node, no children
  localparam node_t NODE_NONE = '{leaf: 1'b0, left: -10'sd1, right: -10'sd1,
                                  symbol: 8'd0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LATCH,
    S_STEP,
    S_CHILD,
    S_EOS,
    S_FINAL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic cfg_we;
    logic fetch;
    logic latch;
    logic leaf_cur;
    logic miss;
    logic go_child;
    logic eval_child;
    logic eos_end;
    logic push_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_decode;
    logic nbits_zero;
    logic cur_leaf;
    logic child_missing;
    logic child_leaf;
    logic bits_last;
    logic node_ok;
    logic root_ok;
    logic walking;
    logic eos;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/htwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the node table of the decoder.
`timescale 1ns / 1ps
`default_nettype none

module htwd_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/htwd_ctrl.sv -----
// Sequencer of the tree walk: node fetch, per-bit step and evaluate, and end-of-item states.
// Depends on htwd_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module htwd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cfg_valid,
  input  htwd_pkg::status_t status,
  output logic              in_ready,
  output logic              cfg_ready,
  output htwd_pkg::cmd_t    cmd
);

  import htwd_pkg::*;

  state_t state;
  state_t state_next;
  logic   stall;

  // A new result cannot be taken while the held one waits for the output
  assign stall = status.pend_valid && !status.out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.in_decode) begin
          if (status.nbits_zero) begin
            state_next = S_EOS;
          end else if (status.node_ok) begin
            state_next = S_STEP;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: state_next = S_LATCH;
      S_LATCH: state_next = S_STEP;
      S_STEP: begin
        if (status.cur_leaf) begin
          if (!stall) begin
            if (status.bits_last) begin
              state_next = S_EOS;
            end else if (status.root_ok) begin
              state_next = S_STEP;
            end else begin
              state_next = S_FETCH;
            end
          end
        end else if (status.child_missing) begin
          if (!stall) begin
            state_next = S_EOS;
          end
        end else begin
          state_next = S_CHILD;
        end
      end
      S_CHILD: begin
        if (!(status.child_leaf && stall)) begin
          if (status.bits_last) begin
            state_next = S_EOS;
          end else if (!status.child_leaf || status.root_ok) begin
            state_next = S_STEP;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_EOS: begin
        if (!(status.eos && status.walking && stall)) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.cfg_we = cfg_valid && (state == S_IDLE);
    case (state)
      S_IDLE:  cmd.accept = in_valid;
      S_FETCH: cmd.fetch  = 1'b1;
      S_LATCH: cmd.latch  = 1'b1;
      S_STEP: begin
        if (status.cur_leaf) begin
          cmd.leaf_cur = !stall;
        end else if (status.child_missing) begin
          cmd.miss = !stall;
        end else begin
          cmd.go_child = 1'b1;
        end
      end
      S_CHILD: cmd.eval_child = !(status.child_leaf && stall);
      S_EOS:   cmd.eos_end = status.eos && !(status.walking && stall);
      S_FINAL: cmd.push_last = !stall;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/htwd_datapath.sv -----
// Datapath of the decoder: node table, node caches, bit shifter, result registers.
// Depends on htwd_pkg and htwd_ram.
`timescale 1ns / 1ps
`default_nettype none

module htwd_datapath #(
  parameter int MAX_NODES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  htwd_pkg::cmd_t     cmd,
  output htwd_pkg::status_t  status,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               mode,
  input  logic [8:0]         node_index,
  input  logic               node_is_leaf,
  input  logic signed [9:0]  node_left,
  input  logic signed [9:0]  node_right,
  input  logic [7:0]         node_symbol,
  input  logic [7:0]         data_byte,
  input  logic [3:0]         bit_count,
  input  logic               end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] symbol,
  output logic               error,
  output logic               last
);

  import htwd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_NODES);

  // Configuration
  logic [15:0] offset;
  logic [8:0]  root;

  // Walk state and node caches
  node_t       node;
  logic        node_ok;
  node_t       root_node;
  logic        root_ok;
  logic        walking;
  logic [8:0]  walk_node;
  logic        fetch_oor;

  // Bits of the current byte
  logic [7:0]  shreg;
  logic [3:0]  bits_left;
  logic        eos;

  // Held result and output register
  logic [15:0] pend_sym;
  logic        pend_err;
  logic        pend_valid;
  logic [15:0] out_sym;
  logic        out_err;
  logic        out_last;

  // Memory side
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_rdata;
  node_t             rd_node;

  logic [8:0]        cur_idx;
  logic              cur_oor;
  logic signed [9:0] child_idx;
  logic              child_missing;
  logic              node_in_range;
  logic [3:0]        nbits;
  logic              res_new;
  logic [15:0]       res_sym;
  logic              res_err;
  logic              out_free;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [8:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[ADDR_W-1:0];
  endfunction

  assign rd_node = node_t'(ram_rdata);

  // Node the walk stands on, and the child chosen by the next bit
  assign cur_idx       = walking ? walk_node : root;
  assign cur_oor       = (32'(cur_idx) >= 32'(MAX_NODES));
  assign child_idx     = shreg[0] ? node.right : node.left;
  assign child_missing = child_idx[9] || (32'(child_idx[8:0]) >= 32'(MAX_NODES));
  assign node_in_range = (32'(node_index) < 32'(MAX_NODES));
  assign nbits         = (bit_count > 4'(BYTE_BITS)) ? 4'(BYTE_BITS) : bit_count;

  // Table write on load items, reads for node fetch and child step
  assign ram_we    = cmd.accept && (mode == MODE_LOAD) && node_in_range;
  assign ram_waddr = to_addr(node_index);
  assign ram_wdata = NODE_W'({node_is_leaf, node_left, node_right, node_symbol});
  assign ram_re    = cmd.fetch || cmd.go_child;
  assign ram_raddr = cmd.fetch ? to_addr(cur_idx) : to_addr(child_idx[8:0]);

  htwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result produced this cycle, if any
  assign res_new = cmd.leaf_cur || cmd.miss || (cmd.eval_child && rd_node.leaf) ||
                   (cmd.eos_end && walking);
  assign res_err = cmd.miss || cmd.eos_end;
  always_comb begin
    if (cmd.leaf_cur) begin
      res_sym = 16'(node.symbol) + offset;
    end else if (cmd.eval_child) begin
      res_sym = 16'(rd_node.symbol) + offset;
    end else begin
      res_sym = 16'd0;
    end
  end

  assign out_free = !out_valid || out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= 16'd0;
      root       <= 9'd0;
      node_ok    <= 1'b0;
      root_ok    <= 1'b0;
      walking    <= 1'b0;
      bits_left  <= 4'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Configuration writes; a new root drops the cached root node
      if (cmd.cfg_we && (cfg_index == REG_SYMBOL_OFFSET)) begin
        offset <= cfg_data;
      end
      if (cmd.cfg_we && (cfg_index == REG_ROOT_INDEX)) begin
        root    <= cfg_data[8:0];
        root_ok <= 1'b0;
        if (!walking) begin
          node_ok <= 1'b0;
        end
      end

      // Take an item: a load invalidates both caches
      if (cmd.accept) begin
        if (mode == MODE_LOAD) begin
          node_ok <= 1'b0;
          root_ok <= 1'b0;
        end else begin
          bits_left <= nbits;
        end
      end

      if (cmd.latch) begin
        node_ok <= 1'b1;
        if (!walking) begin
          root_ok <= 1'b1;
        end
      end

      // Step over one bit, or drop the rest of the byte on a missing child
      if (cmd.leaf_cur || cmd.eval_child) begin
        bits_left <= bits_left - 4'd1;
      end
      if (cmd.miss) begin
        bits_left <= 4'd0;
      end

      // Return to the root, or descend into an inner child
      if (cmd.leaf_cur || cmd.miss || cmd.eos_end ||
          (cmd.eval_child && rd_node.leaf)) begin
        walking <= 1'b0;
        node_ok <= root_ok;
      end else if (cmd.eval_child) begin
        walking <= 1'b1;
        node_ok <= 1'b1;
      end

      // Hold one result back so that the last one of an item can be marked
      if (res_new) begin
        pend_valid <= 1'b1;
      end else if (cmd.push_last) begin
        pend_valid <= 1'b0;
      end

      if ((res_new || cmd.push_last) && pend_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shreg <= data_byte;
      eos   <= end_of_stream;
    end else if (cmd.leaf_cur || cmd.eval_child) begin
      shreg <= shreg >> 1;
    end

    if (cmd.fetch) begin
      fetch_oor <= cur_oor;
    end

    if (cmd.latch) begin
      node <= fetch_oor ? NODE_NONE : rd_node;
      if (!walking) begin
        root_node <= fetch_oor ? NODE_NONE : rd_node;
      end
    end else if (cmd.leaf_cur || cmd.miss || cmd.eos_end ||
                 (cmd.eval_child && rd_node.leaf)) begin
      node <= root_node;
    end else if (cmd.eval_child) begin
      node      <= rd_node;
      walk_node <= child_idx[8:0];
    end

    if (res_new) begin
      pend_sym <= res_sym;
      pend_err <= res_err;
    end

    if ((res_new || cmd.push_last) && pend_valid) begin
      out_sym  <= pend_sym;
      out_err  <= pend_err;
      out_last <= cmd.push_last;
    end
  end

  assign symbol = out_sym;
  assign error  = out_err;
  assign last   = out_last;

  // Status to the controller
  assign status.in_decode     = (mode == MODE_DECODE);
  assign status.nbits_zero    = (nbits == 4'd0);
  assign status.cur_leaf      = node.leaf;
  assign status.child_missing = child_missing;
  assign status.child_leaf    = rd_node.leaf;
  assign status.bits_last     = (bits_left == 4'd1);
  assign status.node_ok       = node_ok;
  assign status.root_ok       = root_ok;
  assign status.walking       = walking;
  assign status.eos           = eos;
  assign status.pend_valid    = pend_valid;
  assign status.out_free      = out_free;

endmodule

`default_nettype wire

// ----- sv/huffman_tree_walk_decoder.sv -----
// Huffman tree-walk decoder. Load items (mode 0) write one tree node into the
// node table. Decode items (mode 1) walk the tree one bit at a time, least
// significant bit first: each bit takes a child read from the node table,
// then an evaluation of the returned node; a leaf at the start of a code is
// handled by the step alone, and a node not yet cached after a load or a
// root change first needs a fetch and a latch. The next item is taken once
// the last result sits in the output register.
// Results are held back by one so the final result of an item carries last.
// Configuration: index 0 sets symbol_offset, index 1 sets root_index; write
// only while the block is idle. Depends on htwd_pkg, htwd_ctrl, htwd_datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_walk_decoder #(
  parameter int MAX_NODES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [8:0]         node_index,
  input  logic               node_is_leaf,
  input  logic signed [9:0]  node_left,
  input  logic signed [9:0]  node_right,
  input  logic [7:0]         node_symbol,
  input  logic [7:0]         data_byte,
  input  logic [3:0]         bit_count,
  input  logic               end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] symbol,
  output logic               error,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  import htwd_pkg::*;

  cmd_t    cmd;
  status_t status;

  htwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .status    (status),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  htwd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .node_index    (node_index),
    .node_is_leaf  (node_is_leaf),
    .node_left     (node_left),
    .node_right    (node_right),
    .node_symbol   (node_symbol),
    .data_byte     (data_byte),
    .bit_count     (bit_count),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol        (symbol),
    .error         (error),
    .last          (last)
  );

  // A decode item that is taken always takes the block out of idle
  `ASSERT_NEXT(a_decode_busy, clk, rst, in_valid && in_ready && (mode == MODE_DECODE), !in_ready, "decode item did not leave idle")

  // Error results carry a zero symbol
  `ASSERT_IMPLIES(a_error_zero, clk, rst, out_valid && error, symbol == 16'sd0, "error result with non-zero symbol")

  // A result that is not the last of its item means the item is still in work
  `ASSERT_IMPLIES(a_mid_busy, clk, rst, out_valid && !last, !in_ready, "non-last result while idle")

endmodule

`default_nettype wire
